[rtl/vbyte_delta_postings_decoder_defines.svh]
// ----------------------------------------------------------------------------
// vbyte delta postings decoder defines
// assertion macros used by the decoder's own checks
// ----------------------------------------------------------------------------
`ifndef VBYTE_DELTA_POSTINGS_DECODER_DEFINES_SVH
`define VBYTE_DELTA_POSTINGS_DECODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define VDPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("vdpd check failed");

// next-cycle implication, disabled while in reset
`define VDPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("vdpd check failed");

`endif

[rtl/vdpd_pkg.sv]
// ----------------------------------------------------------------------------
// vdpd_pkg
// types, codes and the impact score rom of the postings decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vdpd_pkg;

  localparam int unsigned MaxPostingsDefault = 256;

  localparam logic [7:0] VbyteDataMask = 8'h7F;
  localparam logic [7:0] VbyteContMask = 8'h80;
  localparam int unsigned VbyteMaxPos  = 4;

  // 2^(c/36.06) = 2^(50c/1803), exp evaluated in q30
  localparam int unsigned ExpScale   = 50;
  localparam int unsigned ExpDivisor = 1803;
  localparam int unsigned TaylorTerms = 24;
  localparam logic [63:0] Q30One     = 64'd1 << 30;
  localparam logic [63:0] Ln2Q30     = 64'd744261118;
  localparam logic [63:0] RoundHalf  = 64'd1 << 13;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DOCS   = 2'd1,
    PH_SCORES = 2'd2
  } phase_e;

  typedef enum logic {
    KIND_DOC   = 1'b0,
    KIND_SCORE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        chunk_start;
    logic [31:0] chunk_last_doc_id;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  posting_index;
    logic [31:0] doc_id;
    logic [23:0] score;
    logic        last;
    logic        count_overflow;
  } out_t;

  typedef logic [23:0] impact_rom_t [256];

  function automatic logic [23:0] impact_rom_entry(input int unsigned c);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    n    = 64'((ExpScale * c) / ExpDivisor);
    r    = 64'((ExpScale * c) % ExpDivisor);
    z    = (r * Ln2Q30) / ExpDivisor;
    term = Q30One;
    sum  = Q30One;
    for (int unsigned i = 1; i <= TaylorTerms; i++) begin
      term = ((term * z) >> 30) / 64'(i);
      sum  = sum + term;
    end
    v = (sum << n) - Q30One;
    return 24'((v + RoundHalf) >> 14);
  endfunction

  function automatic impact_rom_t build_impact_rom();
    impact_rom_t rom;
    for (int unsigned c = 0; c < 256; c++) begin
      rom[c] = impact_rom_entry(c);
    end
    rom[0] = '0;
    return rom;
  endfunction

  localparam impact_rom_t ImpactRom = build_impact_rom();

endpackage

[rtl/vdpd_stream_if.sv]
// ----------------------------------------------------------------------------
// vdpd_stream_if
// valid/ready stream channel carrying one payload struct per transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vdpd_stream_if #(
  parameter type payload_t = vdpd_pkg::in_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/vbyte_delta_postings_decoder.sv]
// ----------------------------------------------------------------------------
// vbyte_delta_postings_decoder
// variable-byte delta decoder for posting chunks with impact score mapping
// ----------------------------------------------------------------------------
// Takes one chunk byte per transaction and returns at most one result per
// byte: a document id when a variable-byte gap completes, or an impact score
// from the rom while the score bytes of the chunk are read. The decode, the
// delta add with its compare to the chunk's last id and the rom lookup all sit
// between the decoder state and one output register, so a byte can be accepted
// every cycle while the output is not stalled. The input is ready while
// the output register is empty or being taken in the same cycle; a stall
// on the output holds the input for as long as it lasts. No clearing pass
// follows reset.
`timescale 1ns / 1ps

`include "vbyte_delta_postings_decoder_defines.svh"

module vbyte_delta_postings_decoder #(
  parameter int unsigned MAX_POSTINGS = vdpd_pkg::MaxPostingsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vdpd_stream_if.sink   in_i,
  vdpd_stream_if.source out_o
);

  localparam int unsigned CntW = $clog2(MAX_POSTINGS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_POSTINGS);

  vdpd_pkg::phase_e phase_q, phase_d;
  logic [31:0]      accum_q, accum_d;
  logic [2:0]       byte_pos_q, byte_pos_d;
  logic [31:0]      prev_doc_q, prev_doc_d;
  logic             have_prev_q, have_prev_d;
  logic [31:0]      target_q, target_d;
  logic [CntW-1:0]  total_q, total_d;
  logic [CntW-1:0]  score_pos_q, score_pos_d;
  logic             ovf_seen_q, ovf_seen_d;
  logic             out_valid_q, out_valid_d;
  vdpd_pkg::out_t   out_q, out_d;

  vdpd_pkg::in_t    pl;
  logic             in_acc;
  logic             has_result;

  // chunk state as seen by this byte, after a possible chunk restart
  vdpd_pkg::phase_e eff_phase;
  logic [31:0]      eff_accum;
  logic [2:0]       eff_pos;
  logic [31:0]      eff_prev;
  logic             eff_have;
  logic [31:0]      eff_target;
  logic [CntW-1:0]  eff_total;
  logic [CntW-1:0]  eff_score_pos;
  logic             eff_ovf_seen;

  logic [38:0]      part_wide;
  logic [31:0]      accum_new;
  logic [31:0]      doc_sum;
  logic [31:0]      doc_id;
  logic             doc_done;
  logic             doc_match;
  logic             doc_ovf;
  logic [CntW:0]    score_next;
  logic             score_last;
  logic [CntW+7:0]  doc_idx_ext;
  logic [CntW+7:0]  score_idx_ext;

  assign pl         = in_i.payload;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    if (pl.chunk_start) begin
      eff_phase     = vdpd_pkg::PH_DOCS;
      eff_accum     = '0;
      eff_pos       = '0;
      eff_prev      = '0;
      eff_have      = 1'b0;
      eff_target    = pl.chunk_last_doc_id;
      eff_total     = '0;
      eff_score_pos = '0;
      eff_ovf_seen  = 1'b0;
    end else begin
      eff_phase     = phase_q;
      eff_accum     = accum_q;
      eff_pos       = byte_pos_q;
      eff_prev      = prev_doc_q;
      eff_have      = have_prev_q;
      eff_target    = target_q;
      eff_total     = total_q;
      eff_score_pos = score_pos_q;
      eff_ovf_seen  = ovf_seen_q;
    end
  end

  // shift-or of the 7 data bits, bits beyond 32 dropped
  always_comb begin
    part_wide = 39'(pl.data_byte & vdpd_pkg::VbyteDataMask);
    case (eff_pos)
      3'd0:    part_wide = part_wide;
      3'd1:    part_wide = part_wide << 7;
      3'd2:    part_wide = part_wide << 14;
      3'd3:    part_wide = part_wide << 21;
      3'd4:    part_wide = part_wide << 28;
      default: part_wide = '0;
    endcase
  end

  assign accum_new = eff_accum | part_wide[31:0];
  assign doc_sum   = eff_prev + accum_new;
  assign doc_id    = eff_have ? doc_sum : accum_new;
  assign doc_done  = (pl.data_byte & vdpd_pkg::VbyteContMask) == 8'h00;
  assign doc_match = doc_id == eff_target;
  assign doc_ovf   = eff_total >= MaxCnt;

  assign score_next = {1'b0, eff_score_pos} + 1'b1;
  assign score_last = score_next >= {1'b0, eff_total};

  assign doc_idx_ext   = {8'b0, eff_total};
  assign score_idx_ext = {8'b0, eff_score_pos};

  // phase next state
  always_comb begin
    phase_d = phase_q;
    if (in_acc) begin
      case (eff_phase)
        vdpd_pkg::PH_IDLE:   phase_d = vdpd_pkg::PH_IDLE;
        vdpd_pkg::PH_DOCS:   phase_d = (doc_done && doc_match) ? vdpd_pkg::PH_SCORES
                                                               : vdpd_pkg::PH_DOCS;
        vdpd_pkg::PH_SCORES: phase_d = score_last ? vdpd_pkg::PH_IDLE
                                                  : vdpd_pkg::PH_SCORES;
        default:             phase_d = vdpd_pkg::PH_IDLE;
      endcase
    end
  end

  // chunk state and result
  always_comb begin
    accum_d     = accum_q;
    byte_pos_d  = byte_pos_q;
    prev_doc_d  = prev_doc_q;
    have_prev_d = have_prev_q;
    target_d    = target_q;
    total_d     = total_q;
    score_pos_d = score_pos_q;
    ovf_seen_d  = ovf_seen_q;
    has_result  = 1'b0;
    out_d       = '0;
    if (in_acc) begin
      accum_d     = eff_accum;
      byte_pos_d  = eff_pos;
      prev_doc_d  = eff_prev;
      have_prev_d = eff_have;
      target_d    = eff_target;
      total_d     = eff_total;
      score_pos_d = eff_score_pos;
      ovf_seen_d  = eff_ovf_seen;
      case (eff_phase)
        vdpd_pkg::PH_DOCS: begin
          if (!doc_done) begin
            accum_d = accum_new;
            if (eff_pos != 3'd7) begin
              byte_pos_d = eff_pos + 3'd1;
            end
          end else begin
            accum_d     = '0;
            byte_pos_d  = '0;
            prev_doc_d  = doc_id;
            have_prev_d = 1'b1;
            if (doc_ovf) begin
              ovf_seen_d = 1'b1;
            end else begin
              total_d = eff_total + 1'b1;
            end
            has_result           = 1'b1;
            out_d.kind           = vdpd_pkg::KIND_DOC;
            out_d.posting_index  = doc_idx_ext[7:0];
            out_d.doc_id         = doc_id;
            out_d.count_overflow = doc_ovf;
          end
        end
        vdpd_pkg::PH_SCORES: begin
          score_pos_d          = score_next[CntW-1:0];
          has_result           = 1'b1;
          out_d.kind           = vdpd_pkg::KIND_SCORE;
          out_d.posting_index  = score_idx_ext[7:0];
          out_d.score          = vdpd_pkg::ImpactRom[pl.data_byte];
          out_d.last           = score_last;
          out_d.count_overflow = eff_ovf_seen;
        end
        default: begin
          has_result = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = has_result;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= vdpd_pkg::PH_IDLE;
      accum_q     <= '0;
      byte_pos_q  <= '0;
      prev_doc_q  <= '0;
      have_prev_q <= 1'b0;
      target_q    <= '0;
      total_q     <= '0;
      score_pos_q <= '0;
      ovf_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      accum_q     <= accum_d;
      byte_pos_q  <= byte_pos_d;
      prev_doc_q  <= prev_doc_d;
      have_prev_q <= have_prev_d;
      target_q    <= target_d;
      total_q     <= total_d;
      score_pos_q <= score_pos_d;
      ovf_seen_q  <= ovf_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && has_result) begin
      out_q <= out_d;
    end
  end

  // a transaction is only taken when the output register has room
  `VDPD_ASSERT_IMPL(a_accept_room, clk_i, rst_ni, in_acc,
                    !out_valid_q || out_o.ready)
  // the count never passes its saturation limit
  `VDPD_ASSERT_IMPL(a_total_bound, clk_i, rst_ni, 1'b1, total_q <= MaxCnt)
  // while scores are read, the score position stays below the posting count
  `VDPD_ASSERT_IMPL(a_score_pos, clk_i, rst_ni, phase_q == vdpd_pkg::PH_SCORES,
                    score_pos_q < total_q)
  // the final score of a chunk leaves the decoder idle
  `VDPD_ASSERT_NEXT(a_last_idle, clk_i, rst_ni,
                    in_acc && !pl.chunk_start && phase_q == vdpd_pkg::PH_SCORES && score_last,
                    phase_q == vdpd_pkg::PH_IDLE && out_valid_q && out_q.last)

endmodule

[sim/tb_vbyte_delta_postings_decoder.sv]
// ----------------------------------------------------------------------------
// tb_vbyte_delta_postings_decoder
// self-checking bench for the variable-byte delta postings decoder: a short
// table of chunk bytes, then random chunks (well-formed, broken, oversized
// and padded), with random gaps and stalls on both channels. every result
// transaction is compared field by field, against the given values on table
// rows that list them and against an in-bench decoder model otherwise
`timescale 1ns / 1ps

module tb_vbyte_delta_postings_decoder;

  localparam int unsigned MaxPostings = vdpd_pkg::MaxPostingsDefault;
  localparam int unsigned RandomItems = 1750;
  localparam int unsigned StallLimit  = 4000;

  // 2^(c/36.06) = 2^(50c/1803), fraction part as a q30 taylor series
  localparam logic [63:0] ExpNum  = 64'd50;
  localparam logic [63:0] ExpDen  = 64'd1803;
  localparam logic [63:0] Ln2Fix  = 64'd744261118;
  localparam logic [63:0] FixOne  = 64'd1 << 30;

  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_GIVEN = 2'd2
  } chk_e;

  typedef struct packed {
    logic [7:0]      data;
    logic            start;
    logic [31:0]     end_id;
    chk_e            chk;
    vdpd_pkg::kind_e kind;
    logic [7:0]      idx;
    logic [31:0]     doc;
    logic [23:0]     score;
    logic            last;
    logic            ovf;
  } dir_row_t;

  typedef struct packed {
    vdpd_pkg::in_t  item;
    chk_e           chk;
    vdpd_pkg::out_t given;
    logic           drain;
  } stim_t;

  localparam int unsigned DirRows = 24;
  localparam dir_row_t DirTable [DirRows] = '{
    // byte outside a chunk
    '{8'h05, 1'b0, 32'hDEADBEEF, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    // one posting with id zero, then a zero impact byte
    '{8'h00, 1'b1, 32'h00000000, CHK_GIVEN, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 32'h12345678, CHK_GIVEN, vdpd_pkg::KIND_SCORE, 8'd0, 32'd0, 24'd0, 1'b1,
      1'b0},
    '{8'h3C, 1'b0, 32'hFFFFFFFF, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    // ten-byte integer, high bits dropped, position saturates
    '{8'hFF, 1'b1, 32'hFFFFFFFF, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 32'h00000000, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 32'hAAAAAAAA, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 32'h55555555, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 32'h00000000, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 32'h00000000, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 32'h00000000, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 32'h00000000, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 32'h00000000, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'h01, 1'b0, 32'h00000000, CHK_GIVEN, vdpd_pkg::KIND_DOC, 8'd0, 32'hFFFFFFFF, 24'd0,
      1'b0, 1'b0},
    '{8'hFF, 1'b0, 32'h00000000, CHK_MODEL, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    // chunk restarted while its ids are still being read
    '{8'h01, 1'b1, 32'h00000064, CHK_MODEL, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'h87, 1'b1, 32'h00000107, CHK_NONE, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'h02, 1'b0, 32'h00000000, CHK_GIVEN, vdpd_pkg::KIND_DOC, 8'd0, 32'h107, 24'd0, 1'b0,
      1'b0},
    '{8'h24, 1'b0, 32'h00000000, CHK_MODEL, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    // two postings by delta, restarted while the scores are read
    '{8'h03, 1'b1, 32'h00000005, CHK_MODEL, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'h02, 1'b0, 32'h00000000, CHK_MODEL, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 32'h00000000, CHK_MODEL, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 32'h00000000, CHK_GIVEN, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0},
    '{8'h7F, 1'b0, 32'h00000000, CHK_MODEL, vdpd_pkg::KIND_DOC, 8'd0, 32'd0, 24'd0, 1'b0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  vdpd_stream_if #(.payload_t(vdpd_pkg::in_t))  in_if  ();
  vdpd_stream_if #(.payload_t(vdpd_pkg::out_t)) out_if ();

  vbyte_delta_postings_decoder #(
    .MAX_POSTINGS(MaxPostings)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  stim_t          byte_plan [$];
  vdpd_pkg::out_t pending_results [$];
  int unsigned    taken_bytes = 0;
  int unsigned    mismatches = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    calm_count = 0;
  bit             calm = 1'b0;
  bit             drain_next = 1'b0;
  logic [23:0]    impact_tab [256];

  // decoder model state
  vdpd_pkg::phase_e dec_phase = vdpd_pkg::PH_IDLE;
  logic [31:0]      acc = '0;
  logic [2:0]       grp_pos = '0;
  logic [31:0]      prev_id = '0;
  bit               seen_first = 1'b0;
  logic [31:0]      end_id = '0;
  int unsigned      post_cnt = 0;
  int unsigned      score_cnt = 0;
  bit               chunk_ovf = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [23:0] impact_score(input int unsigned c);
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    whole = (ExpNum * 64'(c)) / ExpDen;
    frac  = (ExpNum * 64'(c)) % ExpDen;
    x     = (frac * Ln2Fix) / ExpDen;
    term  = FixOne;
    sum   = FixOne;
    for (int unsigned k = 1; k <= 24; k++) begin
      term = ((term * x) >> 30) / 64'(k);
      sum  = sum + term;
    end
    v = (sum << whole) - FixOne;
    return 24'((v + (64'd1 << 13)) >> 14);
  endfunction

  // one accepted byte through the model, 1 when it yields a result
  function automatic bit decode_byte(input vdpd_pkg::in_t it, output vdpd_pkg::out_t res);
    logic [63:0] part;
    logic [31:0] id;
    res = '0;
    if (it.chunk_start) begin
      end_id     = it.chunk_last_doc_id;
      acc        = '0;
      grp_pos    = '0;
      prev_id    = '0;
      seen_first = 1'b0;
      post_cnt   = 0;
      score_cnt  = 0;
      chunk_ovf  = 1'b0;
      dec_phase  = vdpd_pkg::PH_DOCS;
    end
    if (dec_phase == vdpd_pkg::PH_DOCS) begin
      if (grp_pos <= 3'd4) begin
        part = 64'(it.data_byte[6:0]) << (7 * grp_pos);
        acc  = acc | part[31:0];
      end
      if (it.data_byte[7]) begin
        if (grp_pos < 3'd7) grp_pos = grp_pos + 3'd1;
        return 1'b0;
      end
      id         = seen_first ? prev_id + acc : acc;
      prev_id    = id;
      seen_first = 1'b1;
      acc        = '0;
      grp_pos    = '0;
      res.kind          = vdpd_pkg::KIND_DOC;
      res.posting_index = 8'(post_cnt);
      res.doc_id        = id;
      if (post_cnt >= MaxPostings) begin
        res.count_overflow = 1'b1;
        chunk_ovf          = 1'b1;
      end else begin
        post_cnt++;
      end
      if (id == end_id) dec_phase = vdpd_pkg::PH_SCORES;
      return 1'b1;
    end
    if (dec_phase == vdpd_pkg::PH_SCORES) begin
      res.kind          = vdpd_pkg::KIND_SCORE;
      res.posting_index = 8'(score_cnt);
      score_cnt++;
      res.score          = impact_tab[it.data_byte];
      res.last           = (score_cnt >= post_cnt);
      res.count_overflow = chunk_ovf;
      if (res.last) dec_phase = vdpd_pkg::PH_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_result(input vdpd_pkg::out_t got);
    vdpd_pkg::out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %b, want %b", got.kind, want.kind));
    if (got.posting_index !== want.posting_index)
      report_mismatch($sformatf("posting_index %0d, want %0d",
                                got.posting_index, want.posting_index));
    if (got.doc_id !== want.doc_id)
      report_mismatch($sformatf("doc_id %h, want %h", got.doc_id, want.doc_id));
    if (got.score !== want.score)
      report_mismatch($sformatf("score %h, want %h", got.score, want.score));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    if (got.count_overflow !== want.count_overflow)
      report_mismatch($sformatf("count_overflow %b, want %b",
                                got.count_overflow, want.count_overflow));
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_width_value();
    int unsigned w;
    w = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 14) : $urandom_range(1, 32);
    return $urandom & (32'hFFFFFFFF >> (32 - w));
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic st, input logic [31:0] tgt,
                           input bit counted, inout int unsigned made);
    stim_t s;
    s = '0;
    s.item.data_byte         = b;
    s.item.chunk_start       = st;
    s.item.chunk_last_doc_id = tgt;
    s.chk                    = CHK_MODEL;
    s.drain                  = drain_next;
    drain_next               = 1'b0;
    byte_plan.push_back(s);
    if (counted) made++;
  endtask

  // padded form keeps five groups plus junk above bit 31 and extra groups
  task automatic push_vbyte(input logic [31:0] value, input bit padded, input logic st,
                            input logic [31:0] tgt, inout int unsigned made);
    logic [31:0] v;
    logic [6:0]  top;
    int unsigned extra;
    bit          first;
    first = 1'b1;
    if (!padded) begin
      v = value;
      while (v >= 32'd128) begin
        push_byte({1'b1, v[6:0]}, st & first, first ? tgt : $urandom, 1'b1, made);
        first = 1'b0;
        v = v >> 7;
      end
      push_byte({1'b0, v[6:0]}, st & first, first ? tgt : $urandom, 1'b1, made);
    end else begin
      for (int k = 0; k < 4; k++) begin
        push_byte({1'b1, value[7*k +: 7]}, st & first, first ? tgt : $urandom, 1'b1, made);
        first = 1'b0;
      end
      top   = {3'($urandom), value[31:28]};
      extra = $urandom_range(0, 4);
      if (extra == 0) begin
        push_byte({1'b0, top}, 1'b0, $urandom, 1'b1, made);
      end else begin
        push_byte({1'b1, top}, 1'b0, $urandom, 1'b1, made);
        repeat (extra - 1) push_byte({1'b1, 7'($urandom)}, 1'b0, $urandom, 1'b1, made);
        push_byte({1'b0, 7'($urandom)}, 1'b0, $urandom, 1'b1, made);
      end
    end
  endtask

  // force_n of zero picks a random chunk, otherwise a clean chunk of that size
  task automatic add_chunk(input int unsigned force_n, inout int unsigned made);
    logic [31:0] gaps [$];
    logic [31:0] id;
    logic [31:0] tgt;
    int unsigned n_post;
    int unsigned n_score;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (force_n != 0) n_post = force_n;
    else if (pick < 70) n_post = $urandom_range(1, 6);
    else if (pick < 95) n_post = $urandom_range(7, 40);
    else n_post = 1;
    id = '0;
    for (int unsigned k = 0; k < n_post; k++) begin
      gaps.push_back((force_n != 0) ? 32'($urandom_range(1, 200)) : rand_width_value());
      id = (k == 0) ? gaps[k] : id + gaps[k];
    end
    tgt = (force_n == 0 && $urandom_range(0, 9) == 0) ? 32'($urandom) : id;
    if ($urandom_range(0, 49) == 0) drain_next = 1'b1;
    for (int unsigned k = 0; k < n_post; k++)
      push_vbyte(gaps[k], force_n == 0 && $urandom_range(0, 9) == 0, k == 0, tgt, made);
    n_score = (n_post > MaxPostings) ? MaxPostings : n_post;
    if (force_n == 0 && $urandom_range(0, 6) == 0) n_score = $urandom_range(0, n_score);
    repeat (n_score) push_byte(8'($urandom), 1'b0, $urandom, 1'b1, made);
    // stray bytes between chunks
    if (force_n == 0 && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0, $urandom, 1'b0, made);
  endtask

  // input and result transactions
  always @(posedge clk_i) begin
    vdpd_pkg::out_t res;
    stim_t s;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) check_result(out_if.payload);
      if (in_if.valid && in_if.ready) begin
        s = byte_plan[taken_bytes];
        taken_bytes++;
        if (decode_byte(in_if.payload, res) && s.chk == CHK_MODEL)
          pending_results.push_back(res);
        if (s.chk == CHK_GIVEN) pending_results.push_back(s.given);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stretches without any idling on either side
  always @(posedge clk_i) begin
    calm_count <= calm_count + 1;
    if (calm_count % 256 == 255) calm <= ($urandom_range(0, 3) == 0);
  end

  initial begin : result_sink
    int unsigned hold_n;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      hold_n = pick_gap();
      if (hold_n > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_n) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin : byte_source
    stim_t       s;
    dir_row_t    row;
    int unsigned made;
    int unsigned gap_n;
    bit          big_done;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    rst_ni        = 1'b0;
    made          = 0;
    big_done      = 1'b0;
    for (int c = 0; c < 256; c++) impact_tab[c] = impact_score(c);
    impact_tab[0] = '0;

    for (int r = 0; r < DirRows; r++) begin
      row = DirTable[r];
      s   = '0;
      s.item.data_byte         = row.data;
      s.item.chunk_start       = row.start;
      s.item.chunk_last_doc_id = row.end_id;
      s.chk                    = row.chk;
      s.given.kind             = row.kind;
      s.given.posting_index    = row.idx;
      s.given.doc_id           = row.doc;
      s.given.score            = row.score;
      s.given.last             = row.last;
      s.given.count_overflow   = row.ovf;
      byte_plan.push_back(s);
    end
    drain_next = 1'b1;
    while (made < RandomItems) begin
      if (!big_done && made >= 300) begin
        big_done = 1'b1;
        add_chunk(MaxPostings + $urandom_range(1, 3), made);
      end else begin
        add_chunk(0, made);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (byte_plan[i]) begin
      gap_n = pick_gap();
      if (byte_plan[i].drain || gap_n > 0) begin
        in_if.valid <= 1'b0;
        if (byte_plan[i].drain) begin
          @(posedge clk_i);
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        repeat (gap_n) @(posedge clk_i);
      end
      in_if.valid   <= 1'b1;
      in_if.payload <= byte_plan[i].item;
      do @(posedge clk_i); while (!in_if.ready);
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
